// ===== design/mct_pkg.sv =====
// Shared types and constants of the missing chunk tally.
`default_nettype none

package mct_pkg;

    // Fixed field widths
    localparam int CNT_W  = 11;
    localparam int WORD_W = 10;
    localparam int FUNC_W = 2;

    // Default sizing
    localparam int DEF_MAX_CHUNKS = 1024;
    localparam int DEF_LIST_WORDS = 32;
    localparam int DEF_ADDR_W     = 10;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LIST  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADD,
        ST_NOP,
        ST_CLEAR,
        ST_FM_SKIP,
        ST_CHK_NEXT,
        ST_RUN_SCAN,
        ST_RUN_LO,
        ST_FIND,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] chunk_word;
        logic              word_valid;
        logic              last;
        logic              complete;
        logic              already_present;
        logic              out_of_range;
    } result_t;

endpackage

`default_nettype wire

// ===== design/mct_bitmap.sv =====
// One-bit-per-chunk received map with one write port and one registered read port.
`default_nettype none

module mct_bitmap
    import mct_pkg::*;
#(
    parameter int ADDR_W = DEF_ADDR_W
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic              wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic                   rd_data
);

    logic mem [2**ADDR_W];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/missing_chunk_tally.sv =====
// Top level of the missing chunk tally: received-chunk map, list sequencer and result register.
`default_nettype none

// Received-chunk tally for one transfer of chunk_count chunks (saturated at
// MAX_CHUNKS). An add transfer marks one chunk in a one-bit-per-chunk map and
// reports a repeat or an out-of-range number; a clear transfer empties the map;
// a list transfer scans the map and returns up to LIST_WORDS missing-chunk
// words (a lone gap as one word, a run as highest then lowest), or a single
// result with complete set. All work goes through one map with one write and
// one read port and one index incrementer under a small sequencer, one item at
// a time; in_ready is high only while the sequencer is idle. An add is accepted
// in the idle state and finished in the add state, which uses the registered
// map read and updates the entry as the result leaves. A clear sweeps the whole
// map, one entry per cycle. A list scans the map chunk by chunk from the first
// missing chunk up to the last one reported; chunks below the remembered first
// missing chunk are never rescanned. After reset a clearing sweep of the whole
// map runs before the first item is taken; configuration writes are taken at
// any time. Results go through an output register, so a waiting result does
// not block the next input transfer; a stalled output holds the sequencer only
// where it has a result to hand over or a list word to decide.

module missing_chunk_tally
    import mct_pkg::*;
#(
    parameter int MAX_CHUNKS = DEF_MAX_CHUNKS,
    parameter int LIST_WORDS = DEF_LIST_WORDS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CNT_W-1:0]  chunk_count,

    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [FUNC_W-1:0] func,
    input  wire logic [WORD_W-1:0] chunk_number,

    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [WORD_W-1:0]      chunk_word,
    output logic                   word_valid,
    output logic                   last,
    output logic                   complete,
    output logic                   already_present,
    output logic                   out_of_range
);

    // Map address width and depth, index width able to hold the count plus one
    localparam int AW     = $clog2(MAX_CHUNKS);
    localparam int DEPTH  = 2**AW;
    localparam int NW_MIN = $clog2(MAX_CHUNKS + 2);
    localparam int NW     = (NW_MIN > CNT_W) ? NW_MIN : CNT_W;
    localparam int LCW    = $clog2(LIST_WORDS + 1);

    localparam logic [NW-1:0]  MAX_N     = NW'(MAX_CHUNKS);
    localparam logic [NW-1:0]  LAST_ADDR = NW'(DEPTH - 1);
    localparam logic [LCW-1:0] LW_N      = LCW'(LIST_WORDS);
    localparam logic [LCW-1:0] LW_M1     = LCW'(LIST_WORDS - 1);

    state_t            state_reg, state_next;
    logic [NW-1:0]     idx_reg, idx_next;
    logic [NW-1:0]     cn_reg, cn_next;
    logic [NW-1:0]     fm_reg, fm_next;
    logic [LCW-1:0]    cnt_reg, cnt_next;
    logic [WORD_W-1:0] hold_word_reg, hold_word_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [CNT_W-1:0]  count_reg;
    result_t           out_res_reg;
    logic              out_valid_reg;

    logic              accept;
    logic [NW-1:0]     eff_n;
    logic [NW-1:0]     idx_inc;
    logic [NW-1:0]     idx_dec;
    logic [LCW-1:0]    cnt_inc;
    logic              idx_lt_n;
    logic              single;
    logic              can_emit;
    logic              rd_data;
    logic              wr_en;
    logic              wr_data;
    logic              emit;
    result_t           emit_res;
    logic              produce;
    logic [WORD_W-1:0] produce_word;

    // ------------------------------------------------------------------
    // Received map
    // ------------------------------------------------------------------
    mct_bitmap #(
        .ADDR_W (AW)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (idx_next[AW-1:0]),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Shared conditions
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;

    // Saturate the configured count at the map size
    assign eff_n    = (NW'(count_reg) > MAX_N) ? MAX_N : NW'(count_reg);
    assign idx_inc  = idx_reg + 1'b1;
    assign idx_dec  = idx_reg - 1'b1;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign idx_lt_n = (idx_reg < eff_n);
    // In CHK_NEXT idx points one past the run start: a lone gap ends there
    assign single   = (idx_reg == eff_n) || rd_data;
    assign can_emit = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (idx_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        FUNC_ADD:   state_next = ST_ADD;
                        FUNC_LIST:  state_next = ST_FM_SKIP;
                        FUNC_CLEAR: state_next = ST_CLEAR;
                        default:    state_next = ST_NOP;
                    endcase
                end
            end
            ST_ADD, ST_NOP, ST_FLUSH:
            begin
                if (can_emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (idx_reg == LAST_ADDR && can_emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FM_SKIP:
            begin
                if (!idx_lt_n)
                begin
                    if (can_emit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!rd_data)
                begin
                    state_next = ST_CHK_NEXT;
                end
            end
            ST_CHK_NEXT:
            begin
                if (can_emit)
                begin
                    if (single)
                    begin
                        state_next = (cnt_inc >= LW_N) ? ST_FLUSH : ST_FIND;
                    end
                    else
                    begin
                        state_next = (cnt_reg == LW_M1) ? ST_FLUSH : ST_RUN_SCAN;
                    end
                end
            end
            ST_RUN_SCAN:
            begin
                if (!(idx_lt_n && !rd_data) && can_emit)
                begin
                    state_next = ST_RUN_LO;
                end
            end
            ST_RUN_LO:
            begin
                if (can_emit)
                begin
                    state_next = (cnt_inc >= LW_N) ? ST_FLUSH : ST_FIND;
                end
            end
            ST_FIND:
            begin
                if (!idx_lt_n)
                begin
                    state_next = ST_FLUSH;
                end
                else if (!rd_data)
                begin
                    state_next = ST_CHK_NEXT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath control and result generation
    // ------------------------------------------------------------------
    always_comb
    begin
        idx_next        = idx_reg;
        cn_next         = cn_reg;
        fm_next         = fm_reg;
        cnt_next        = cnt_reg;
        hold_word_next  = hold_word_reg;
        hold_valid_next = hold_valid_reg;
        wr_en           = 1'b0;
        wr_data         = 1'b0;
        emit            = 1'b0;
        emit_res        = '0;
        produce         = 1'b0;
        produce_word    = '0;

        unique case (state_reg)
            ST_INIT:
            begin
                // Clear one map entry per cycle after reset
                wr_en    = 1'b1;
                idx_next = idx_inc;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        FUNC_ADD:
                        begin
                            idx_next = NW'(chunk_number);
                        end
                        FUNC_LIST:
                        begin
                            idx_next        = fm_reg;
                            cnt_next        = '0;
                            hold_valid_next = 1'b0;
                        end
                        FUNC_CLEAR:
                        begin
                            idx_next = '0;
                            fm_next  = '0;
                        end
                        default:
                        begin
                            idx_next = idx_reg;
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                // Mark the chunk only in the cycle the result leaves
                if (can_emit)
                begin
                    emit                     = 1'b1;
                    emit_res.last            = 1'b1;
                    emit_res.out_of_range    = !idx_lt_n;
                    emit_res.already_present = idx_lt_n && rd_data;
                    wr_en                    = idx_lt_n && !rd_data;
                    wr_data                  = 1'b1;
                end
            end
            ST_NOP:
            begin
                if (can_emit)
                begin
                    emit          = 1'b1;
                    emit_res.last = 1'b1;
                end
            end
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (idx_reg != LAST_ADDR)
                begin
                    idx_next = idx_inc;
                end
                else if (can_emit)
                begin
                    emit          = 1'b1;
                    emit_res.last = 1'b1;
                end
            end
            ST_FM_SKIP:
            begin
                // Advance the remembered first missing chunk past received ones
                if (!idx_lt_n)
                begin
                    if (can_emit)
                    begin
                        emit              = 1'b1;
                        emit_res.last     = 1'b1;
                        emit_res.complete = 1'b1;
                    end
                end
                else if (rd_data)
                begin
                    idx_next = idx_inc;
                    fm_next  = idx_inc;
                end
                else
                begin
                    cn_next  = idx_reg;
                    idx_next = idx_inc;
                end
            end
            ST_CHK_NEXT:
            begin
                if (can_emit)
                begin
                    if (single)
                    begin
                        produce      = 1'b1;
                        produce_word = cn_reg[WORD_W-1:0];
                        cnt_next     = cnt_inc;
                        idx_next     = idx_inc;
                    end
                    else if (cnt_reg == LW_M1)
                    begin
                        // No room for two words: cut the run to its first chunk
                        produce      = 1'b1;
                        produce_word = cn_reg[WORD_W-1:0];
                        cnt_next     = cnt_inc;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end
            ST_RUN_SCAN:
            begin
                if (idx_lt_n && !rd_data)
                begin
                    idx_next = idx_inc;
                end
                else if (can_emit)
                begin
                    produce      = 1'b1;
                    produce_word = idx_dec[WORD_W-1:0];
                    cnt_next     = cnt_inc;
                end
            end
            ST_RUN_LO:
            begin
                if (can_emit)
                begin
                    produce      = 1'b1;
                    produce_word = cn_reg[WORD_W-1:0];
                    cnt_next     = cnt_inc;
                    idx_next     = idx_inc;
                end
            end
            ST_FIND:
            begin
                if (idx_lt_n)
                begin
                    if (rd_data)
                    begin
                        idx_next = idx_inc;
                    end
                    else
                    begin
                        cn_next  = idx_reg;
                        idx_next = idx_inc;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (can_emit)
                begin
                    emit                = 1'b1;
                    emit_res.chunk_word = hold_word_reg;
                    emit_res.word_valid = 1'b1;
                    emit_res.last       = 1'b1;
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase

        // Hold each list word until the next one shows it was not the last
        if (produce)
        begin
            hold_word_next  = produce_word;
            hold_valid_next = 1'b1;
            if (hold_valid_reg)
            begin
                emit                = 1'b1;
                emit_res.chunk_word = hold_word_reg;
                emit_res.word_valid = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            idx_reg        <= '0;
            fm_reg         <= '0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            fm_reg         <= fm_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= chunk_count;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        cn_reg        <= cn_next;
        hold_word_reg <= hold_word_next;
        if (emit)
        begin
            out_res_reg <= emit_res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign chunk_word      = out_res_reg.chunk_word;
    assign word_valid      = out_res_reg.word_valid;
    assign last            = out_res_reg.last;
    assign complete        = out_res_reg.complete;
    assign already_present = out_res_reg.already_present;
    assign out_of_range    = out_res_reg.out_of_range;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A complete report never carries a list word and always closes the item
    a_complete_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && complete) |-> (!word_valid && last && !already_present && !out_of_range))
        else $error("complete result carries other flags");

    // The list never grows past its word budget
    a_word_budget: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LW_N)
        else $error("list word count above budget");

    // The first missing pointer never exceeds the map size
    a_fm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fm_reg <= MAX_N)
        else $error("first missing pointer past map size");

    // An add marks the map only for an in-range chunk, and reports the add
    a_add_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD && wr_en) |-> (idx_lt_n && wr_data && emit))
        else $error("add wrote the map out of range or without a result");

endmodule

`default_nettype wire
